/* hw/rtl/windowed_stereo_mean_stddev_top_assert.svh */
// assertion macros used by wsms_dpath.sv
`ifndef WINDOWED_STEREO_MEAN_STDDEV_TOP_ASSERT_SVH
`define WINDOWED_STEREO_MEAN_STDDEV_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define WSMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsms check failed");
`define WSMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsms check failed");
`else
`define WSMS_ASSERT_NOW(label, clk, rst, ante, cons)
`define WSMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/wsms_pkg.sv */
package wsms_pkg;

   localparam int WINDOW_MAX_DEFAULT = 256;
   localparam int SAMPLE_BITS        = 16;
   localparam int TIME_BITS          = 48;
   localparam int BLOCK_BITS         = 13;
   localparam int TICK_BITS          = 16;
   localparam int WLEN_BITS          = 9;
   localparam int DELTA_BITS         = BLOCK_BITS + TICK_BITS;
   localparam int SPAN_BITS          = WLEN_BITS + DELTA_BITS;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LEN  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIVE_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_RATE   = 2'd2;

   localparam logic [WLEN_BITS-1:0] WINDOW_LEN_RESET = 9'd64;
   localparam logic [TICK_BITS-1:0] TICK_RATE_RESET  = 16'd1;

   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic signed [SAMPLE_BITS-1:0] last_left;
      logic signed [SAMPLE_BITS-1:0] last_right;
      logic [BLOCK_BITS-1:0]         block_frames;
   } req_item_type;

   typedef struct packed {
      logic                          stats_valid;
      logic signed [SAMPLE_BITS-1:0] mean_left;
      logic signed [SAMPLE_BITS-1:0] mean_right;
      logic [SAMPLE_BITS-1:0]        spread_left;
      logic [SAMPLE_BITS-1:0]        spread_right;
      logic signed [TIME_BITS-1:0]   window_start;
      logic signed [TIME_BITS-1:0]   window_end;
   } rsp_item_type;

   typedef struct packed {
      logic [WLEN_BITS-1:0] window_len;
      logic                 live_enable;
      logic [TICK_BITS-1:0] tick_rate;
   } cfg_type;

   typedef enum logic [1:0] {
      DIV_MEAN_L,
      DIV_MEAN_R,
      DIV_VAR_L,
      DIV_VAR_R
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_DROP,
      ST_PUSH_STORE,
      ST_PUSH_START,
      ST_SUM_PASS,
      ST_MEAN_L,
      ST_MEAN_R,
      ST_VAR_PASS,
      ST_VAR_L,
      ST_VAR_R,
      ST_ROOT_L,
      ST_ROOT_R,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic        load_req;
      logic        push_drop;
      logic        push_store;
      logic        push_start;
      logic        pass_start;
      logic        pass_square;
      logic        div_start;
      div_sel_type div_sel;
      logic        sqrt_start;
      logic        sqrt_right;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic in_query;
      logic live;
      logic empty;
      logic pass_done;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } dp_stat_type;

endpackage

/* hw/rtl/wsms_div.sv */
module wsms_div #(
   parameter int DIVIDEND_BITS = 41,
   parameter int DIVISOR_BITS  = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     busy,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] quo_ff;
   logic [DIVISOR_BITS-1:0]  rem_ff;
   logic [DIVISOR_BITS-1:0]  dvs_ff;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_BITS'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(DIVIDEND_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_BITS-2:0], fits};
         rem_ff <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/wsms_sqrt.sv */
module wsms_sqrt #(
   parameter int RADICAND_BITS = 41
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [RADICAND_BITS-1:0]                radicand,
   output logic                                    busy,
   output logic                                    done,
   output logic [(RADICAND_BITS + 1) / 2 - 1:0]    root
);

   localparam int SQW      = RADICAND_BITS + (RADICAND_BITS % 2);
   localparam int H        = SQW / 2;
   localparam int CNT_BITS = $clog2(H + 1);

   logic [SQW-1:0]      x_ff;
   logic [H:0]          rem_ff;
   logic [H-1:0]        root_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [H+2:0]        trial;
   logic [H+2:0]        test;
   logic [H+2:0]        diff;
   logic                fits;

   always_comb begin
      trial = {rem_ff, x_ff[SQW-1 -: 2]};
      test  = {1'b0, root_ff, 2'b01};
      diff  = trial - test;
      fits  = trial >= test;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_BITS'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(H);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= SQW'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[SQW-3:0], 2'b00};
         rem_ff  <= fits ? diff[H:0] : trial[H:0];
         root_ff <= {root_ff[H-2:0], fits};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule

/* hw/rtl/wsms_dpath.sv */
`include "windowed_stereo_mean_stddev_top_assert.svh"

module wsms_dpath #(
   parameter int WINDOW_MAX = wsms_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wsms_pkg::cfg_type     cfg,
   input  wsms_pkg::req_item_type req_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output wsms_pkg::rsp_item_type rsp_data,
   input  wsms_pkg::dp_cmd_type  cmd,
   output wsms_pkg::dp_stat_type stat
);

   localparam int SB    = wsms_pkg::SAMPLE_BITS;
   localparam int TB    = wsms_pkg::TIME_BITS;
   localparam int DB    = wsms_pkg::DELTA_BITS;
   localparam int PB    = wsms_pkg::SPAN_BITS;
   localparam int AW    = $clog2(WINDOW_MAX);
   localparam int CW    = $clog2(WINDOW_MAX + 1);
   localparam int SUMW  = SB + CW;
   localparam int VARW  = 2 * SB + CW;
   localparam int ROOTW = (VARW + 1) / 2;

   function automatic logic [AW-1:0] wrap_slot(input logic [CW:0] s);
      logic [CW:0] t;
      t = s - (CW+1)'(WINDOW_MAX);
      if (s >= (CW+1)'(WINDOW_MAX)) begin
         return t[AW-1:0];
      end
      return s[AW-1:0];
   endfunction

   wsms_pkg::req_item_type req_ff;
   logic [CW-1:0]           fill_ff;
   logic [AW-1:0]           oldest_ff;
   logic [TB-1:0]           end_ff;
   logic [TB-1:0]           start_ff;
   logic [DB-1:0]           delta_ff;
   logic [PB-1:0]           span_ff;

   logic [2*SB-1:0] frame_mem [WINDOW_MAX];
   logic [2*SB-1:0] rd_data_ff;

   logic [CW-1:0] cap;
   logic [CW-1:0] drop;
   logic          full;
   logic [AW-1:0] oldest_in;
   logic [AW-1:0] wr_slot;
   logic [AW-1:0] rd_addr;

   logic          pass_active_ff;
   logic          square_ff;
   logic [CW-1:0] idx_ff;
   logic          v1_ff;
   logic          v1_last_ff;
   logic          v2_ff;
   logic          v2_last_ff;
   logic          last_issue;
   logic          pass_done;
   logic          pass_done_ff;

   logic signed [SB-1:0]     x_l;
   logic signed [SB-1:0]     x_r;
   logic signed [SB:0]       d_l;
   logic signed [SB:0]       d_r;
   logic signed [2*SB+1:0]   p_l;
   logic signed [2*SB+1:0]   p_r;
   logic [2*SB-1:0]          sq_l_ff;
   logic [2*SB-1:0]          sq_r_ff;
   logic signed [SUMW-1:0]   sum_l_ff;
   logic signed [SUMW-1:0]   sum_r_ff;
   logic [VARW-1:0]          var_l_ff;
   logic [VARW-1:0]          var_r_ff;
   logic signed [SB-1:0]     mean_l_ff;
   logic signed [SB-1:0]     mean_r_ff;
   logic [SB-1:0]            spread_l_ff;
   logic [SB-1:0]            spread_r_ff;

   logic [SUMW-1:0]          sum_neg_l;
   logic [SUMW-1:0]          sum_neg_r;
   logic [SUMW-1:0]          abs_l;
   logic [SUMW-1:0]          abs_r;
   logic [VARW-1:0]          dividend;
   logic [VARW-1:0]          quotient;
   logic [SB-1:0]            q_low;
   logic [SB-1:0]            q_neg;
   logic                     div_busy;
   logic                     div_done;
   wsms_pkg::div_sel_type    div_sel_ff;

   logic [VARW-1:0]          radicand;
   logic [ROOTW-1:0]         root;
   logic                     sqrt_busy;
   logic                     sqrt_done;
   logic                     sqrt_right_ff;

   logic                     out_valid_ff;
   wsms_pkg::rsp_item_type   out_data_ff;
   wsms_pkg::rsp_item_type   out_in;

   // window trim and slot arithmetic
   always_comb begin
      if (32'(cfg.window_len) > 32'(WINDOW_MAX)) begin
         cap = CW'(WINDOW_MAX);
      end else if (cfg.window_len == '0) begin
         cap = CW'(1);
      end else begin
         cap = CW'(cfg.window_len);
      end
      full      = fill_ff >= cap;
      drop      = fill_ff - cap + CW'(1);
      oldest_in = wrap_slot((CW+1)'(oldest_ff) + (CW+1)'(drop));
      wr_slot   = wrap_slot((CW+1)'(oldest_ff) + (CW+1)'(fill_ff));
      rd_addr   = wrap_slot((CW+1)'(oldest_ff) + (CW+1)'(idx_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.push_store) begin
         frame_mem[wr_slot] <= {req_ff.last_left, req_ff.last_right};
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.push_drop) begin
         delta_ff <= DB'(req_ff.block_frames) * DB'(cfg.tick_rate);
      end
      if (cmd.push_store) begin
         span_ff <= PB'(cfg.window_len) * PB'(delta_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         oldest_ff <= '0;
         end_ff    <= '0;
         start_ff  <= '0;
      end else begin
         if (cmd.push_drop && full) begin
            oldest_ff <= oldest_in;
            fill_ff   <= cap - CW'(1);
         end
         if (cmd.push_store) begin
            fill_ff <= fill_ff + CW'(1);
            end_ff  <= end_ff + TB'(delta_ff);
         end
         if (cmd.push_start) begin
            start_ff <= end_ff - TB'(span_ff);
         end
      end
   end

   // window walk: read, then accumulate, squaring first on the variance pass
   assign last_issue = idx_ff == (fill_ff - CW'(1));
   assign pass_done  = (v1_ff && v1_last_ff && !square_ff) || (v2_ff && v2_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_active_ff <= 1'b0;
         square_ff      <= 1'b0;
         idx_ff         <= '0;
         v1_ff          <= 1'b0;
         v1_last_ff     <= 1'b0;
         v2_ff          <= 1'b0;
         v2_last_ff     <= 1'b0;
         pass_done_ff   <= 1'b0;
      end else begin
         v1_ff        <= pass_active_ff;
         v1_last_ff   <= pass_active_ff && last_issue;
         v2_ff        <= v1_ff && square_ff;
         v2_last_ff   <= v1_last_ff && square_ff;
         pass_done_ff <= pass_done;
         if (cmd.pass_start) begin
            pass_active_ff <= 1'b1;
            square_ff      <= cmd.pass_square;
            idx_ff         <= '0;
         end else if (pass_active_ff) begin
            idx_ff <= idx_ff + CW'(1);
            if (last_issue) begin
               pass_active_ff <= 1'b0;
            end
         end
      end
   end

   always_comb begin
      x_l = signed'(rd_data_ff[2*SB-1:SB]);
      x_r = signed'(rd_data_ff[SB-1:0]);
      d_l = (SB+1)'(x_l) - (SB+1)'(mean_l_ff);
      d_r = (SB+1)'(x_r) - (SB+1)'(mean_r_ff);
      p_l = d_l * d_l;
      p_r = d_r * d_r;
   end

   always_ff @(posedge clock) begin
      if (cmd.pass_start && !cmd.pass_square) begin
         sum_l_ff <= '0;
         sum_r_ff <= '0;
      end else if (v1_ff && !square_ff) begin
         sum_l_ff <= sum_l_ff + SUMW'(x_l);
         sum_r_ff <= sum_r_ff + SUMW'(x_r);
      end
      if (v1_ff && square_ff) begin
         sq_l_ff <= p_l[2*SB-1:0];
         sq_r_ff <= p_r[2*SB-1:0];
      end
      if (cmd.pass_start && cmd.pass_square) begin
         var_l_ff <= '0;
         var_r_ff <= '0;
      end else if (v2_ff) begin
         var_l_ff <= var_l_ff + VARW'(sq_l_ff);
         var_r_ff <= var_r_ff + VARW'(sq_r_ff);
      end else if (div_done && div_sel_ff == wsms_pkg::DIV_VAR_L) begin
         var_l_ff <= quotient;
      end else if (div_done && div_sel_ff == wsms_pkg::DIV_VAR_R) begin
         var_r_ff <= quotient;
      end
   end

   // shared divider for means and variances
   always_comb begin
      sum_neg_l = SUMW'(-sum_l_ff);
      sum_neg_r = SUMW'(-sum_r_ff);
      abs_l     = sum_l_ff[SUMW-1] ? sum_neg_l : SUMW'(sum_l_ff);
      abs_r     = sum_r_ff[SUMW-1] ? sum_neg_r : SUMW'(sum_r_ff);
      unique case (cmd.div_sel)
         wsms_pkg::DIV_MEAN_L: dividend = VARW'(abs_l);
         wsms_pkg::DIV_MEAN_R: dividend = VARW'(abs_r);
         wsms_pkg::DIV_VAR_L:  dividend = var_l_ff;
         wsms_pkg::DIV_VAR_R:  dividend = var_r_ff;
         default:              dividend = var_l_ff;
      endcase
      q_low = quotient[SB-1:0];
      q_neg = -q_low;
   end

   wsms_div #(
      .DIVIDEND_BITS(VARW),
      .DIVISOR_BITS (CW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(dividend),
      .divisor (fill_ff),
      .busy    (div_busy),
      .done    (div_done),
      .quotient(quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_sel_ff <= cmd.div_sel;
      end
      if (div_done && div_sel_ff == wsms_pkg::DIV_MEAN_L) begin
         mean_l_ff <= sum_l_ff[SUMW-1] ? q_neg : q_low;
      end
      if (div_done && div_sel_ff == wsms_pkg::DIV_MEAN_R) begin
         mean_r_ff <= sum_r_ff[SUMW-1] ? q_neg : q_low;
      end
   end

   assign radicand = cmd.sqrt_right ? var_r_ff : var_l_ff;

   wsms_sqrt #(
      .RADICAND_BITS(VARW)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.sqrt_start),
      .radicand(radicand),
      .busy    (sqrt_busy),
      .done    (sqrt_done),
      .root    (root)
   );

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         sqrt_right_ff <= cmd.sqrt_right;
      end
      if (sqrt_done && !sqrt_right_ff) begin
         spread_l_ff <= root[SB-1:0];
      end
      if (sqrt_done && sqrt_right_ff) begin
         spread_r_ff <= root[SB-1:0];
      end
   end

   // output register
   always_comb begin
      out_in              = '0;
      out_in.stats_valid  = fill_ff != '0;
      if (out_in.stats_valid) begin
         out_in.mean_left    = mean_l_ff;
         out_in.mean_right   = mean_r_ff;
         out_in.spread_left  = spread_l_ff;
         out_in.spread_right = spread_r_ff;
      end
      out_in.window_start = start_ff;
      out_in.window_end   = end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      stat.in_query  = req_data.req_type == wsms_pkg::REQ_QUERY;
      stat.live      = cfg.live_enable;
      stat.empty     = fill_ff == '0;
      stat.pass_done = pass_done_ff;
      stat.div_done  = div_done;
      stat.sqrt_done = sqrt_done;
      stat.out_free  = !out_valid_ff || !rsp_stall;
   end

   `WSMS_ASSERT_NOW(a_fill_max, clock, reset, 1'b1, 32'(fill_ff) <= WINDOW_MAX)
   `WSMS_ASSERT_NOW(a_out_no_overwrite, clock, reset, cmd.out_load, !out_valid_ff || !rsp_stall)
   `WSMS_ASSERT_NOW(a_unit_idle_on_start, clock, reset, cmd.div_start || cmd.sqrt_start, !div_busy && !sqrt_busy)
   `WSMS_ASSERT_NOW(a_pass_nonempty, clock, reset, cmd.pass_start, !pass_active_ff && fill_ff != '0)
   `WSMS_ASSERT_NEXT(a_store_fills, clock, reset, cmd.push_store, fill_ff != '0)

endmodule

/* hw/rtl/wsms_ctrl.sv */
module wsms_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wsms_pkg::dp_stat_type stat,
   output wsms_pkg::dp_cmd_type  cmd
);

   wsms_pkg::state_type state_ff;
   wsms_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         wsms_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (stat.in_query) begin
                  if (stat.empty) begin
                     state_in = wsms_pkg::ST_RESULT;
                  end else begin
                     cmd.pass_start = 1'b1;
                     state_in       = wsms_pkg::ST_SUM_PASS;
                  end
               end else if (stat.live) begin
                  state_in = wsms_pkg::ST_PUSH_DROP;
               end
            end
         end
         wsms_pkg::ST_PUSH_DROP: begin
            cmd.push_drop = 1'b1;
            state_in      = wsms_pkg::ST_PUSH_STORE;
         end
         wsms_pkg::ST_PUSH_STORE: begin
            cmd.push_store = 1'b1;
            state_in       = wsms_pkg::ST_PUSH_START;
         end
         wsms_pkg::ST_PUSH_START: begin
            cmd.push_start = 1'b1;
            state_in       = wsms_pkg::ST_IDLE;
         end
         wsms_pkg::ST_SUM_PASS: begin
            if (stat.pass_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = wsms_pkg::DIV_MEAN_L;
               state_in      = wsms_pkg::ST_MEAN_L;
            end
         end
         wsms_pkg::ST_MEAN_L: begin
            if (stat.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = wsms_pkg::DIV_MEAN_R;
               state_in      = wsms_pkg::ST_MEAN_R;
            end
         end
         wsms_pkg::ST_MEAN_R: begin
            if (stat.div_done) begin
               cmd.pass_start  = 1'b1;
               cmd.pass_square = 1'b1;
               state_in        = wsms_pkg::ST_VAR_PASS;
            end
         end
         wsms_pkg::ST_VAR_PASS: begin
            if (stat.pass_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = wsms_pkg::DIV_VAR_L;
               state_in      = wsms_pkg::ST_VAR_L;
            end
         end
         wsms_pkg::ST_VAR_L: begin
            if (stat.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = wsms_pkg::DIV_VAR_R;
               state_in      = wsms_pkg::ST_VAR_R;
            end
         end
         wsms_pkg::ST_VAR_R: begin
            if (stat.div_done) begin
               cmd.sqrt_start = 1'b1;
               state_in       = wsms_pkg::ST_ROOT_L;
            end
         end
         wsms_pkg::ST_ROOT_L: begin
            if (stat.sqrt_done) begin
               cmd.sqrt_start = 1'b1;
               cmd.sqrt_right = 1'b1;
               state_in       = wsms_pkg::ST_ROOT_R;
            end
         end
         wsms_pkg::ST_ROOT_R: begin
            if (stat.sqrt_done) begin
               state_in = wsms_pkg::ST_RESULT;
            end
         end
         wsms_pkg::ST_RESULT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = wsms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsms_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/windowed_stereo_mean_stddev_top.sv */
// Sliding window of stereo frames with per-channel mean and standard deviation. A push request
// (req_type 0) stores the block's last frame when live_enable is set, trimming the window to
// window_len frames (at least one, at most WINDOW_MAX), advances the window end time by
// block_frames * tick_rate ticks and sets the start time window_len such steps before the end;
// it returns nothing and, when live, steps through the drop, store and start states before the
// next request is taken. A query request (req_type 1) returns one response with the truncated
// means, the floor square roots of the population variances and both times. It walks the frame
// memory once to sum, divides for both means, walks it again to square and accumulate, divides
// for both variances and takes both roots, with one serial divider and one square-root unit
// serving both channels in turn. An empty window answers with stats_valid low and no walks.
// A finished response waits in an output register, so the next request is taken while it
// stalls. Register writes are always accepted and must only be made while the block is idle.
module windowed_stereo_mean_stddev_top #(
   parameter int WINDOW_MAX = wsms_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  wsms_pkg::req_item_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output wsms_pkg::rsp_item_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wsms_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wsms_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic [wsms_pkg::WLEN_BITS-1:0] window_len_ff;
   logic                           live_enable_ff;
   logic [wsms_pkg::TICK_BITS-1:0] tick_rate_ff;
   wsms_pkg::cfg_type              cfg;
   wsms_pkg::dp_cmd_type           cmd;
   wsms_pkg::dp_stat_type          stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff  <= wsms_pkg::WINDOW_LEN_RESET;
         live_enable_ff <= 1'b0;
         tick_rate_ff   <= wsms_pkg::TICK_RATE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wsms_pkg::CSR_WINDOW_LEN:  window_len_ff  <= csr_data[wsms_pkg::WLEN_BITS-1:0];
            wsms_pkg::CSR_LIVE_ENABLE: live_enable_ff <= csr_data[0];
            wsms_pkg::CSR_TICK_RATE:   tick_rate_ff   <= csr_data[wsms_pkg::TICK_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.window_len  = window_len_ff;
      cfg.live_enable = live_enable_ff;
      cfg.tick_rate   = tick_rate_ff;
   end

   wsms_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   wsms_dpath #(
      .WINDOW_MAX(WINDOW_MAX)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule
